// ----- design/owbm_pkg.sv -----
// owbm_pkg: shared types and constants for the one-wire bus master
// holds command codes, timing phases, register indexes, reset values and queue sizing
// no dependencies
`default_nettype none

package owbm_pkg;

   // timing counter sizing
   localparam int US_COUNT_BITS  = 10;
   localparam int CPU_BITS       = 8;
   localparam int DUR_BITS       = 10;
   localparam int LIM_BITS       = ((DUR_BITS > US_COUNT_BITS) ? DUR_BITS : US_COUNT_BITS) + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   // longest phase the microsecond counter can time
   localparam logic [LIM_BITS-1:0] US_LIMIT = LIM_BITS'(1) << US_COUNT_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CYCLES_PER_US      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_LOW_US       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESENCE_SAMPLE_US = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESENCE_TAIL_US   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_SLOT_US      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_LOW_US        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_SAMPLE_US     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_TAIL_US       = 3'd7;

   // register reset values
   localparam logic [CPU_BITS-1:0] CYCLES_PER_US_RST      = 8'd8;
   localparam logic [DUR_BITS-1:0] RESET_LOW_US_RST       = 10'd700;
   localparam logic [DUR_BITS-1:0] PRESENCE_SAMPLE_US_RST = 10'd75;
   localparam logic [DUR_BITS-1:0] PRESENCE_TAIL_US_RST   = 10'd500;
   localparam logic [DUR_BITS-1:0] WRITE_SLOT_US_RST      = 10'd75;
   localparam logic [DUR_BITS-1:0] READ_LOW_US_RST        = 10'd3;
   localparam logic [DUR_BITS-1:0] READ_SAMPLE_US_RST     = 10'd5;
   localparam logic [DUR_BITS-1:0] READ_TAIL_US_RST       = 10'd70;

   // recovery after each write slot
   localparam logic [DUR_BITS-1:0] WRITE_RECOVERY_US      = 10'd1;

   typedef enum logic [1:0] {
      CMD_NONE       = 2'd0,
      CMD_BUS_RESET  = 2'd1,
      CMD_WRITE_BYTE = 2'd2,
      CMD_READ_BYTE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_WR_SLOT  = 4'd4,
      PH_WR_REC   = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_TAIL  = 4'd8
   } phase_type;

   // one queued tick
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] write_byte;
      logic       line_level;
   } tick_type;

endpackage

`default_nettype wire

// ----- design/owbm_front.sv -----
// owbm_front: accepts request items, decodes the command and queues them
// depends on owbm_pkg
`default_nettype none

module owbm_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [1:0]           req_cmd,
   input  wire  [7:0]           req_write_byte,
   input  wire                  req_line_level,
   output logic                 q_valid,
   output owbm_pkg::tick_type   q_item,
   input  wire                  q_pop
);
   import owbm_pkg::*;

   tick_type                  entry_ff [QUEUE_DEPTH];
   tick_type                  new_item;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push;
   logic                      pop;

   // decode the incoming item
   always_comb begin
      new_item.cmd        = cmd_type'(req_cmd);
      new_item.write_byte = req_write_byte;
      new_item.line_level = req_line_level;
   end

   // queue handshake
   assign req_stall = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// ----- design/owbm_back.sv -----
// owbm_back: timing sequencer, configuration registers and result register
// runs one queued tick per step; depends on owbm_pkg
`default_nettype none

module owbm_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_en,
   input  wire  [owbm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [owbm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire                                   q_valid,
   input  owbm_pkg::tick_type                    q_item,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_drive_low,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [7:0]                            rsp_read_byte,
   output logic                                  rsp_presence
);
   import owbm_pkg::*;

   // configuration
   logic [CPU_BITS-1:0]      cycles_per_us_ff;
   logic [DUR_BITS-1:0]      reset_low_us_ff, presence_sample_us_ff, presence_tail_us_ff;
   logic [DUR_BITS-1:0]      write_slot_us_ff, read_low_us_ff, read_sample_us_ff;
   logic [DUR_BITS-1:0]      read_tail_us_ff;

   // sequencer state
   phase_type                phase_ff, phase_in;
   logic [CPU_BITS-1:0]      prescale_ff, prescale_in;
   logic [US_COUNT_BITS-1:0] us_ff, us_in;
   logic [2:0]               bit_ff, bit_in;
   logic [7:0]               shift_ff, shift_in;
   logic                     presence_ff, presence_in;
   logic [7:0]               result_ff, result_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     drive_ff, busy_ff, done_ff;
   logic                     drive_in, busy_in, done_in;

   logic                     step;
   logic [CPU_BITS-1:0]      cpu_eff;
   logic [DUR_BITS-1:0]      dur_sel;
   logic [LIM_BITS-1:0]      lim;
   logic                     pre_wrap;
   logic                     us_wrap;
   logic                     phase_end;
   logic                     last_bit;

   // a step runs when a tick is queued and the result register is free or not stalled
   assign step      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = step;
   assign last_bit  = (bit_ff == 3'd7);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cycles_per_us_ff      <= CYCLES_PER_US_RST;
         reset_low_us_ff       <= RESET_LOW_US_RST;
         presence_sample_us_ff <= PRESENCE_SAMPLE_US_RST;
         presence_tail_us_ff   <= PRESENCE_TAIL_US_RST;
         write_slot_us_ff      <= WRITE_SLOT_US_RST;
         read_low_us_ff        <= READ_LOW_US_RST;
         read_sample_us_ff     <= READ_SAMPLE_US_RST;
         read_tail_us_ff       <= READ_TAIL_US_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CYCLES_PER_US:      cycles_per_us_ff      <= csr_wdata[CPU_BITS-1:0];
            CSR_RESET_LOW_US:       reset_low_us_ff       <= csr_wdata[DUR_BITS-1:0];
            CSR_PRESENCE_SAMPLE_US: presence_sample_us_ff <= csr_wdata[DUR_BITS-1:0];
            CSR_PRESENCE_TAIL_US:   presence_tail_us_ff   <= csr_wdata[DUR_BITS-1:0];
            CSR_WRITE_SLOT_US:      write_slot_us_ff      <= csr_wdata[DUR_BITS-1:0];
            CSR_READ_LOW_US:        read_low_us_ff        <= csr_wdata[DUR_BITS-1:0];
            CSR_READ_SAMPLE_US:     read_sample_us_ff     <= csr_wdata[DUR_BITS-1:0];
            CSR_READ_TAIL_US:       read_tail_us_ff       <= csr_wdata[DUR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // phase duration select
   always_comb begin
      case (phase_ff)
         PH_RST_LOW:  dur_sel = reset_low_us_ff;
         PH_RST_WAIT: dur_sel = presence_sample_us_ff;
         PH_RST_TAIL: dur_sel = presence_tail_us_ff;
         PH_WR_SLOT:  dur_sel = write_slot_us_ff;
         PH_RD_LOW:   dur_sel = read_low_us_ff;
         PH_RD_WAIT:  dur_sel = read_sample_us_ff;
         PH_RD_TAIL:  dur_sel = read_tail_us_ff;
         default:     dur_sel = WRITE_RECOVERY_US;
      endcase
   end

   // prescaler and microsecond timer end detection; zero counts as one
   always_comb begin
      cpu_eff = (cycles_per_us_ff == '0) ? CPU_BITS'(1) : cycles_per_us_ff;
      if (dur_sel == '0) begin
         lim = LIM_BITS'(1);
      end else if (LIM_BITS'(dur_sel) > US_LIMIT) begin
         lim = US_LIMIT;
      end else begin
         lim = LIM_BITS'(dur_sel);
      end
      pre_wrap  = ({1'b0, prescale_ff} + (CPU_BITS + 1)'(1)) >= {1'b0, cpu_eff};
      us_wrap   = (LIM_BITS'(us_ff) + LIM_BITS'(1)) >= lim;
      phase_end = pre_wrap && us_wrap;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            case (q_item.cmd)
               CMD_BUS_RESET:  phase_in = PH_RST_LOW;
               CMD_WRITE_BYTE: phase_in = PH_WR_SLOT;
               CMD_READ_BYTE:  phase_in = PH_RD_LOW;
               default:        phase_in = PH_IDLE;
            endcase
         end
         PH_RST_LOW:  if (phase_end) phase_in = PH_RST_WAIT;
         PH_RST_WAIT: if (phase_end) phase_in = PH_RST_TAIL;
         PH_RST_TAIL: if (phase_end) phase_in = PH_IDLE;
         PH_WR_SLOT:  if (phase_end) phase_in = PH_WR_REC;
         PH_WR_REC:   if (phase_end) phase_in = last_bit ? PH_IDLE : PH_WR_SLOT;
         PH_RD_LOW:   if (phase_end) phase_in = PH_RD_WAIT;
         PH_RD_WAIT:  if (phase_end) phase_in = PH_RD_TAIL;
         PH_RD_TAIL:  if (phase_end) phase_in = last_bit ? PH_IDLE : PH_RD_LOW;
         default:     phase_in = PH_IDLE;
      endcase
   end

   // timer counters: cleared on any phase change and while idle
   always_comb begin
      if (phase_ff == PH_IDLE || phase_in != phase_ff) begin
         prescale_in = '0;
         us_in       = '0;
      end else if (pre_wrap) begin
         prescale_in = '0;
         us_in       = us_wrap ? '0 : us_ff + US_COUNT_BITS'(1);
      end else begin
         prescale_in = prescale_ff + CPU_BITS'(1);
         us_in       = us_ff;
      end
   end

   // bit counter, shift byte, presence and read result
   always_comb begin
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      result_in   = result_ff;
      done_in     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            bit_in = '0;
            if (q_item.cmd == CMD_WRITE_BYTE) begin
               shift_in = q_item.write_byte;
            end else if (q_item.cmd == CMD_READ_BYTE) begin
               shift_in = '0;
            end
         end
         PH_RST_WAIT: if (phase_end) presence_in = !q_item.line_level;
         PH_RST_TAIL: if (phase_end) done_in = 1'b1;
         PH_WR_REC: begin
            if (phase_end) begin
               bit_in  = last_bit ? 3'd0 : bit_ff + 3'd1;
               done_in = last_bit;
            end
         end
         PH_RD_WAIT: begin
            if (phase_end) begin
               shift_in = shift_ff | (8'(q_item.line_level) << bit_ff);
            end
         end
         PH_RD_TAIL: begin
            if (phase_end) begin
               bit_in  = last_bit ? 3'd0 : bit_ff + 3'd1;
               done_in = last_bit;
               if (last_bit) begin
                  result_in = shift_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // line drive and busy from the new state
   always_comb begin
      case (phase_in)
         PH_RST_LOW: drive_in = 1'b1;
         PH_RD_LOW:  drive_in = 1'b1;
         PH_WR_SLOT: drive_in = !shift_in[bit_in] || (us_in == '0);
         default:    drive_in = 1'b0;
      endcase
      busy_in = (phase_in != PH_IDLE);
   end

   // result handshake
   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         prescale_ff  <= '0;
         us_ff        <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b0;
         result_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff    <= phase_in;
            prescale_ff <= prescale_in;
            us_ff       <= us_in;
            bit_ff      <= bit_in;
            shift_ff    <= shift_in;
            presence_ff <= presence_in;
            result_ff   <= result_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step) begin
         drive_ff <= drive_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = drive_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_byte = result_ff;
   assign rsp_presence  = presence_ff;

endmodule

`default_nettype wire

// ----- design/onewire_bus_master.sv -----
// onewire_bus_master: top level of the one-wire bus master
// instantiates owbm_front and owbm_back; depends on owbm_pkg
`default_nettype none

// Each request item is one tick of the bus timing and yields exactly one response
// item with the line drive, busy, done pulse, last read byte and presence flag after
// that tick. One item is taken per cycle while req_stall is low; the front holds a
// four-item queue and the sequencer steps one queued tick per cycle into a single
// output register unless a stalled response holds it. Back-pressure on the response
// side fills the queue before req_stall rises. Timing registers are to be written
// through the csr port while no command runs, which the block does not enforce; a
// command given while a sequence runs is ignored, and the done tick takes none.

module onewire_bus_master (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_en,
   input  wire  [owbm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [owbm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [1:0]                            req_cmd,
   input  wire  [7:0]                            req_write_byte,
   input  wire                                   req_line_level,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_drive_low,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [7:0]                            rsp_read_byte,
   output logic                                  rsp_presence
);
   import owbm_pkg::*;

   logic     q_valid;
   logic     q_pop;
   tick_type q_item;

   // accept and queue ticks
   owbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_write_byte (req_write_byte),
      .req_line_level (req_line_level),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // run the bus timing
   owbm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive_low (rsp_drive_low),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_byte (rsp_read_byte),
      .rsp_presence  (rsp_presence)
   );

endmodule

`default_nettype wire

// ----- design/owbm_checker.sv -----
// owbm_checker: port-level assertions for the one-wire bus master
// bound to onewire_bus_master; watches the response channel only
`default_nettype none

module owbm_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   rsp_valid,
   input wire                                   rsp_stall,
   input wire                                   rsp_drive_low,
   input wire                                   rsp_busy_res,
   input wire                                   rsp_done_res,
   input wire  [7:0]                            rsp_read_byte,
   input wire                                   rsp_presence
);

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_low)
         && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_read_byte) && $stable(rsp_presence))
      else $error("stalled response item changed");

   // the line is only pulled low while a sequence runs
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("line driven while idle");

   // the done tick leaves the block idle with the line released
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_drive_low)
      else $error("done pulse while busy or driving");

   // no response item right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind onewire_bus_master owbm_checker u_owbm_checker (.*);

`default_nettype wire

// ----- verif/tb_onewire_bus_master.sv -----
// tb_onewire_bus_master: self-checking testbench for the one-wire bus master
// predicts every response item from the accepted request items and the timing registers
// depends on owbm_pkg and onewire_bus_master
`timescale 1ns / 100ps

module tb_onewire_bus_master;
   import owbm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   // one predicted response item
   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       presence;
   } line_state_type;

   // bus timing predictor with its queue of expected line states
   class line_state_predictor;
      int unsigned    reg_val[8];
      phase_type      ph;
      int unsigned    presc;
      int unsigned    usc;
      logic [2:0]     bitpos;
      logic [7:0]     shreg;
      logic [7:0]     rdres;
      logic           seen;
      line_state_type expected_states[$];
      int             errors;

      function new();
         reg_val[CSR_CYCLES_PER_US]      = CYCLES_PER_US_RST;
         reg_val[CSR_RESET_LOW_US]       = RESET_LOW_US_RST;
         reg_val[CSR_PRESENCE_SAMPLE_US] = PRESENCE_SAMPLE_US_RST;
         reg_val[CSR_PRESENCE_TAIL_US]   = PRESENCE_TAIL_US_RST;
         reg_val[CSR_WRITE_SLOT_US]      = WRITE_SLOT_US_RST;
         reg_val[CSR_READ_LOW_US]        = READ_LOW_US_RST;
         reg_val[CSR_READ_SAMPLE_US]     = READ_SAMPLE_US_RST;
         reg_val[CSR_READ_TAIL_US]       = READ_TAIL_US_RST;
         ph     = PH_IDLE;
         presc  = 0;
         usc    = 0;
         bitpos = '0;
         shreg  = '0;
         rdres  = '0;
         seen   = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(int unsigned idx, int unsigned value);
         if (idx == CSR_CYCLES_PER_US) reg_val[idx] = value & 'hFF;
         else reg_val[idx] = value & 'h3FF;
      endfunction

      function bit busy();
         return ph != PH_IDLE;
      endfunction

      function int pending();
         return expected_states.size();
      endfunction

      function void start_phase(phase_type p);
         ph    = p;
         presc = 0;
         usc   = 0;
      endfunction

      // one tick of the prescaled microsecond timer, true when the phase is over
      function bit timer_step(int unsigned dur);
         int unsigned lim;
         int unsigned cpu;
         lim = (dur == 0) ? 1 : dur;
         if (lim > (1 << US_COUNT_BITS)) lim = 1 << US_COUNT_BITS;
         cpu = (reg_val[CSR_CYCLES_PER_US] == 0) ? 1 : reg_val[CSR_CYCLES_PER_US];
         if (presc + 1 < cpu) begin
            presc++;
            return 1'b0;
         end
         presc = 0;
         if (usc + 1 >= lim) begin
            usc = 0;
            return 1'b1;
         end
         usc++;
         return 1'b0;
      endfunction

      // advance the sequencer by one accepted item
      function void note_tick(cmd_type cmd, logic [7:0] wb, logic ln);
         line_state_type st;
         st = '0;
         case (ph)
            PH_IDLE: begin
               bitpos = '0;
               if (cmd == CMD_BUS_RESET) begin
                  start_phase(PH_RST_LOW);
               end else if (cmd == CMD_WRITE_BYTE) begin
                  shreg = wb;
                  start_phase(PH_WR_SLOT);
               end else if (cmd == CMD_READ_BYTE) begin
                  shreg = '0;
                  start_phase(PH_RD_LOW);
               end
            end
            PH_RST_LOW: begin
               if (timer_step(reg_val[CSR_RESET_LOW_US])) start_phase(PH_RST_WAIT);
            end
            PH_RST_WAIT: begin
               if (timer_step(reg_val[CSR_PRESENCE_SAMPLE_US])) begin
                  seen = ~ln;
                  start_phase(PH_RST_TAIL);
               end
            end
            PH_RST_TAIL: begin
               if (timer_step(reg_val[CSR_PRESENCE_TAIL_US])) begin
                  start_phase(PH_IDLE);
                  st.done_res = 1'b1;
               end
            end
            PH_WR_SLOT: begin
               if (timer_step(reg_val[CSR_WRITE_SLOT_US])) start_phase(PH_WR_REC);
            end
            PH_WR_REC: begin
               if (timer_step(WRITE_RECOVERY_US)) begin
                  if (bitpos == 3'd7) begin
                     bitpos = '0;
                     start_phase(PH_IDLE);
                     st.done_res = 1'b1;
                  end else begin
                     bitpos++;
                     start_phase(PH_WR_SLOT);
                  end
               end
            end
            PH_RD_LOW: begin
               if (timer_step(reg_val[CSR_READ_LOW_US])) start_phase(PH_RD_WAIT);
            end
            PH_RD_WAIT: begin
               if (timer_step(reg_val[CSR_READ_SAMPLE_US])) begin
                  shreg = shreg | (8'(ln) << bitpos);
                  start_phase(PH_RD_TAIL);
               end
            end
            PH_RD_TAIL: begin
               if (timer_step(reg_val[CSR_READ_TAIL_US])) begin
                  if (bitpos == 3'd7) begin
                     bitpos = '0;
                     rdres  = shreg;
                     start_phase(PH_IDLE);
                     st.done_res = 1'b1;
                  end else begin
                     bitpos++;
                     start_phase(PH_RD_LOW);
                  end
               end
            end
            default: begin
               start_phase(PH_IDLE);
            end
         endcase

         // line drive after this tick; a one bit only pulls low for its first microsecond
         if (ph == PH_RST_LOW || ph == PH_RD_LOW) st.drive_low = 1'b1;
         else if (ph == PH_WR_SLOT) st.drive_low = (shreg[bitpos] == 1'b0) || (usc == 0);
         st.busy_res  = (ph != PH_IDLE);
         st.read_byte = rdres;
         st.presence  = seen;
         expected_states.push_back(st);
      endfunction

      // compare one response item with the oldest expected line state
      function void check_line_state(logic drive_low, logic busy_res, logic done_res,
                                     logic [7:0] read_byte, logic presence);
         line_state_type want;
         if (expected_states.size() == 0) begin
            $error("response item with no request item waiting for it");
            errors++;
            return;
         end
         want = expected_states.pop_front();
         if (want.drive_low !== drive_low) begin
            $error("drive_low: expected %0d, actual %0d", want.drive_low, drive_low);
            errors++;
         end
         if (want.busy_res !== busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy_res, busy_res);
            errors++;
         end
         if (want.done_res !== done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, done_res);
            errors++;
         end
         if (want.read_byte !== read_byte) begin
            $error("read_byte: expected 0x%02h, actual 0x%02h", want.read_byte, read_byte);
            errors++;
         end
         if (want.presence !== presence) begin
            $error("presence: expected %0d, actual %0d", want.presence, presence);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_cmd;
   logic [7:0]                req_write_byte;
   logic                      req_line_level;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_drive_low;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic [7:0]                rsp_read_byte;
   logic                      rsp_presence;

   line_state_predictor tracker = new;

   bit          idle_on;
   bit          hold_req;
   int          hold_left;
   int unsigned timing_set[8];
   int unsigned cycle_count;

   onewire_bus_master DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_write_byte (req_write_byte),
      .req_line_level (req_line_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_presence   (rsp_presence)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_onewire_bus_master: FAIL");
         $finish;
      end
   end

   // handshake monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_tick(cmd_type'(req_cmd), req_write_byte, req_line_level);
         if (rsp_valid && !rsp_stall)
            tracker.check_line_state(rsp_drive_low, rsp_busy_res, rsp_done_res,
                                     rsp_read_byte, rsp_presence);
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 59;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 14);
         end
      end
   end

   // offer one item and hold it until it is taken
   task automatic send_tick(input cmd_type cmd, input logic [7:0] wb, input logic ln);
      while (idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_write_byte <= wb;
      req_line_level <= ln;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop offering until every expected response item has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.pending() != 0);
   endtask

   function automatic cmd_type noise_cmd();
      if ($urandom_range(99) < 20) return cmd_type'($urandom_range(3));
      return CMD_NONE;
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // line level: mode 2 random, otherwise bit 0 of the mode (0 always low, 1 always high)
   function automatic logic pick_line(int mode);
      if (mode == 2) return 1'($urandom_range(1));
      return mode[0];
   endfunction

   function automatic void pick_timing(int unsigned cpu, int unsigned lo, int unsigned hi);
      timing_set[CSR_CYCLES_PER_US] = cpu;
      for (int i = CSR_RESET_LOW_US; i <= CSR_READ_TAIL_US; i++)
         timing_set[i] = $urandom_range(hi, lo);
   endfunction

   // write all timing registers once the block has gone quiet
   task automatic load_timing();
      drain_results();
      repeat (8) @(negedge clock);
      for (int i = CSR_CYCLES_PER_US; i <= CSR_READ_TAIL_US; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_INDEX_BITS'(i);
         csr_wdata    <= CSR_DATA_BITS'(timing_set[i]);
         tracker.set_reg(i, timing_set[i]);
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // one command from idle, then ticks until the sequence is over
   task automatic run_command(input cmd_type cmd, input logic [7:0] wb, input int line_mode);
      send_tick(cmd, wb, pick_line(line_mode));
      while (tracker.busy()) send_tick(noise_cmd(), rand_byte(), pick_line(line_mode));
   endtask

   // start a command on the current timing, then finish it on the fastest timing
   task automatic run_partial(input cmd_type cmd, input logic [7:0] wb, input int ticks);
      send_tick(cmd, wb, pick_line(2));
      repeat (ticks) send_tick(noise_cmd(), rand_byte(), pick_line(2));
      pick_timing(1, 1, 1);
      load_timing();
      while (tracker.busy()) send_tick(noise_cmd(), rand_byte(), pick_line(2));
   endtask

   // mostly well-formed commands with stray commands while busy
   task automatic run_random(input int n, input int hold_at, input int pause_at);
      cmd_type c;
      for (int k = 0; k < n; k++) begin
         if (k == hold_at) hold_req = 1'b1;
         if (k == pause_at) drain_results();
         if (tracker.busy()) c = noise_cmd();
         else if ($urandom_range(99) < 60) c = cmd_type'($urandom_range(3, 1));
         else c = CMD_NONE;
         send_tick(c, rand_byte(), 1'($urandom_range(1)));
      end
      while (tracker.busy()) send_tick(noise_cmd(), rand_byte(), 1'($urandom_range(1)));
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_NONE;
      req_write_byte = 8'h00;
      req_line_level = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_CYCLES_PER_US;
      csr_wdata      = '0;
      idle_on        = 1'b1;
      hold_req       = 1'b0;
      cycle_count    = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // timing left at reset values, through the first bit's low pulse
      run_partial(CMD_WRITE_BYTE, 8'hA5, 40);

      // fastest timing: presence both ways, byte extremes, idle ticks
      pick_timing(1, 1, 1);
      load_timing();
      send_tick(CMD_NONE, 8'hFF, 1'b0);
      send_tick(CMD_NONE, 8'h00, 1'b1);
      run_command(CMD_BUS_RESET, 8'h00, 0);
      run_command(CMD_BUS_RESET, 8'hFF, 1);
      run_command(CMD_WRITE_BYTE, 8'h00, 2);
      run_command(CMD_WRITE_BYTE, 8'hFF, 2);
      run_command(CMD_WRITE_BYTE, 8'h5A, 2);
      run_command(CMD_READ_BYTE, 8'h00, 1);
      run_command(CMD_READ_BYTE, 8'hFF, 0);
      run_command(CMD_READ_BYTE, 8'h3C, 2);

      // zero prescaler and zero durations behave as one
      pick_timing(0, 0, 0);
      load_timing();
      run_command(CMD_BUS_RESET, 8'h00, 2);
      run_command(CMD_WRITE_BYTE, 8'h81, 2);
      run_command(CMD_READ_BYTE, 8'h00, 2);

      // widest prescaler, written with the upper data bits set, past the first phase
      pick_timing('h3FF, 1, 1);
      load_timing();
      run_partial(CMD_READ_BYTE, 8'h00, 270);

      // longest durations, cut short
      pick_timing(1, 1023, 1023);
      load_timing();
      run_partial(CMD_BUS_RESET, 8'h00, 60);

      // random timing sets with random command streams
      for (int p = 0; p < 5; p++) begin
         pick_timing($urandom_range(2), 0, 3);
         load_timing();
         idle_on = (p != 3);
         run_random(160, (p == 0) ? 100 : -1, (p == 1) ? 150 : -1);
      end
      idle_on = 1'b1;

      drain_results();
      repeat (20) @(negedge clock);
      if (tracker.errors == 0) $display("tb_onewire_bus_master: PASS");
      else $display("tb_onewire_bus_master: FAIL");
      $finish;
   end

endmodule
